@@ hw/rtl/wta_pkg.sv @@
// Shared types, constants and field widths of the warmer thermostat/alarm block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package wta_pkg;

  // Raw sensor field width and the width that holds a saturated reading
  localparam int TEMP_BITS = 18;
  localparam int TEMP_W    = 18;
  localparam int SAT_EXT_W = (TEMP_BITS > TEMP_W) ? TEMP_BITS : TEMP_W;

  localparam int CFG_W  = 13;
  localparam int HOLD_W = 12;
  localparam int DIV_W  = 4;

  localparam int NUM_CFG = 8;
  localparam int CFG_AW  = $clog2(NUM_CFG) + 2;
  localparam int APB_DW  = 32;

  localparam int IN_FIELD_W  = 2 * TEMP_BITS + 4;
  localparam int IN_TDATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 9 + 2 * CFG_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Temperatures in 0.01 C
  localparam int TEMP_LOW        = -20000;
  localparam int TEMP_HIGH       = 85000;
  localparam int SENSOR_MAX      = 5000;
  localparam int SKIN_HIGH_CLASS = 3735;
  localparam int LOW_MARGIN      = 100;
  localparam int HEAT_OFF_MARGIN = 20;
  localparam int HEAT_ON_MARGIN  = 30;
  localparam int EDIT_STEP       = 10;
  localparam int SETPOINT_RESET  = 3650;

  // Register reset values
  localparam int RST_PREHEAT_TARGET   = 3000;
  localparam int RST_SKIN_ALARM_HIGH  = 3720;
  localparam int RST_AIR_ALARM_HIGH   = 3900;
  localparam int RST_SETPOINT_CEILING = 3720;
  localparam int RST_SETPOINT_FLOOR   = 3200;
  localparam int RST_SILENCE_SHORT    = 600;
  localparam int RST_SILENCE_LONG     = 1500;
  localparam int RST_UPDATE_DIVIDER   = 2;

  typedef enum logic [$clog2(NUM_CFG)-1:0] {
    REG_PREHEAT_TARGET,
    REG_SKIN_ALARM_HIGH,
    REG_AIR_ALARM_HIGH,
    REG_SETPOINT_CEILING,
    REG_SETPOINT_FLOOR,
    REG_SILENCE_SHORT,
    REG_SILENCE_LONG,
    REG_UPDATE_DIVIDER
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ALARM_NONE,
    ALARM_SKIN_HIGH,
    ALARM_SKIN_LOW,
    ALARM_AIR_HIGH
  } alarm_kind_t;

  typedef struct packed {
    logic [CFG_W-1:0]  preheat_target;
    logic [CFG_W-1:0]  skin_alarm_high;
    logic [CFG_W-1:0]  air_alarm_high;
    logic [CFG_W-1:0]  setpoint_ceiling;
    logic [CFG_W-1:0]  setpoint_floor;
    logic [HOLD_W-1:0] silence_short;
    logic [HOLD_W-1:0] silence_long;
    logic [DIV_W-1:0]  update_divider;
  } cfg_t;

  typedef struct packed {
    logic signed [TEMP_BITS-1:0] skin_temp;
    logic signed [TEMP_BITS-1:0] air_temp;
    logic                        stop_btn;
    logic                        up_btn;
    logic                        down_btn;
    logic                        set_btn;
  } item_t;

  typedef struct packed {
    logic              heater_on;
    logic              buzzer_on;
    alarm_kind_t       alarm_kind;
    logic              skin_fail;
    logic              air_fail;
    logic              editing;
    logic [CFG_W-1:0]  active_setpoint;
    logic [CFG_W-1:0]  edit_setpoint;
    logic              preheating;
    logic              update_tick;
  } result_t;

endpackage

@@ hw/rtl/wta_cfg_regs.sv @@
// APB-style configuration register file of the warmer thermostat/alarm block.
// Depends on wta_pkg for the register map and the cfg_t bundle.
`timescale 1ns / 1ps

module wta_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [wta_pkg::CFG_AW-1:0] paddr,
  input  logic [wta_pkg::APB_DW-1:0] pwdata,
  output logic [wta_pkg::APB_DW-1:0] prdata,
  output wta_pkg::cfg_t             cfg
);
  import wta_pkg::*;

  cfg_t     cfg_r;
  cfg_idx_t idx;
  logic     wr_en;

  assign idx   = cfg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preheat_target   <= CFG_W'(RST_PREHEAT_TARGET);
      cfg_r.skin_alarm_high  <= CFG_W'(RST_SKIN_ALARM_HIGH);
      cfg_r.air_alarm_high   <= CFG_W'(RST_AIR_ALARM_HIGH);
      cfg_r.setpoint_ceiling <= CFG_W'(RST_SETPOINT_CEILING);
      cfg_r.setpoint_floor   <= CFG_W'(RST_SETPOINT_FLOOR);
      cfg_r.silence_short    <= HOLD_W'(RST_SILENCE_SHORT);
      cfg_r.silence_long     <= HOLD_W'(RST_SILENCE_LONG);
      cfg_r.update_divider   <= DIV_W'(RST_UPDATE_DIVIDER);
    end else if (wr_en) begin
      unique case (idx)
        REG_PREHEAT_TARGET:   cfg_r.preheat_target   <= pwdata[CFG_W-1:0];
        REG_SKIN_ALARM_HIGH:  cfg_r.skin_alarm_high  <= pwdata[CFG_W-1:0];
        REG_AIR_ALARM_HIGH:   cfg_r.air_alarm_high   <= pwdata[CFG_W-1:0];
        REG_SETPOINT_CEILING: cfg_r.setpoint_ceiling <= pwdata[CFG_W-1:0];
        REG_SETPOINT_FLOOR:   cfg_r.setpoint_floor   <= pwdata[CFG_W-1:0];
        REG_SILENCE_SHORT:    cfg_r.silence_short    <= pwdata[HOLD_W-1:0];
        REG_SILENCE_LONG:     cfg_r.silence_long     <= pwdata[HOLD_W-1:0];
        REG_UPDATE_DIVIDER:   cfg_r.update_divider   <= pwdata[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_PREHEAT_TARGET:   prdata = APB_DW'(cfg_r.preheat_target);
      REG_SKIN_ALARM_HIGH:  prdata = APB_DW'(cfg_r.skin_alarm_high);
      REG_AIR_ALARM_HIGH:   prdata = APB_DW'(cfg_r.air_alarm_high);
      REG_SETPOINT_CEILING: prdata = APB_DW'(cfg_r.setpoint_ceiling);
      REG_SETPOINT_FLOOR:   prdata = APB_DW'(cfg_r.setpoint_floor);
      REG_SILENCE_SHORT:    prdata = APB_DW'(cfg_r.silence_short);
      REG_SILENCE_LONG:     prdata = APB_DW'(cfg_r.silence_long);
      REG_UPDATE_DIVIDER:   prdata = APB_DW'(cfg_r.update_divider);
      default:              prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/wta_tick_logic.sv @@
// Per-tick controller state and update logic: preheat, setpoint edit, alarm,
// silence hold-off, heater hysteresis and buzzer. Depends on wta_pkg.
`timescale 1ns / 1ps

module wta_tick_logic (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  wta_pkg::item_t   item,
  input  wta_pkg::cfg_t    cfg,
  output wta_pkg::result_t result
);
  import wta_pkg::*;

  localparam logic signed [TEMP_W-1:0] ZERO_S       = '0;
  localparam logic signed [TEMP_W-1:0] SENSOR_MAX_S = TEMP_W'(SENSOR_MAX);
  localparam logic signed [TEMP_W-1:0] SKIN_CLASS_S = TEMP_W'(SKIN_HIGH_CLASS);
  localparam logic signed [TEMP_W-1:0] LOW_MARGIN_S = TEMP_W'(LOW_MARGIN);
  localparam logic signed [TEMP_W-1:0] OFF_MARGIN_S = TEMP_W'(HEAT_OFF_MARGIN);
  localparam logic signed [TEMP_W-1:0] ON_MARGIN_S  = TEMP_W'(HEAT_ON_MARGIN);
  localparam logic [HOLD_W-1:0]        HOLD_MAX     = '1;

  function automatic logic signed [TEMP_W-1:0] sat_temp(
    input logic signed [TEMP_BITS-1:0] raw
  );
    logic signed [SAT_EXT_W-1:0] ext;
    logic signed [SAT_EXT_W-1:0] lo;
    logic signed [SAT_EXT_W-1:0] hi;
    ext = SAT_EXT_W'(raw);
    lo  = SAT_EXT_W'(TEMP_LOW);
    hi  = SAT_EXT_W'(TEMP_HIGH);
    if (ext < lo) ext = lo;
    if (ext > hi) ext = hi;
    return TEMP_W'(ext);
  endfunction

  function automatic logic signed [TEMP_W-1:0] to_s(input logic [CFG_W-1:0] v);
    return $signed({{(TEMP_W-CFG_W){1'b0}}, v});
  endfunction

  // state
  logic [CFG_W-1:0]  sp_now_r, sp_now_nxt;
  logic [CFG_W-1:0]  sp_draft_r, sp_draft_nxt;
  logic              edit_r, edit_nxt;
  logic              preheat_done_r, preheat_done_nxt;
  logic              pending_r, pending_nxt;
  logic              sil_req_r, sil_req_nxt;
  logic              hold_act_r, hold_act_nxt;
  logic [HOLD_W-1:0] hold_cnt_r, hold_cnt_nxt;
  logic              reached_r, reached_nxt;
  logic [3:0]        btn_prev_r, btn_prev_nxt;
  logic              heater_r, heater_nxt;
  logic              phase_r, phase_nxt;
  logic [DIV_W-1:0]  div_cnt_r, div_cnt_nxt;
  alarm_kind_t       class_r, class_nxt;

  logic signed [TEMP_W-1:0] skin, air, sp_s, sp_lo;
  logic [3:0]               btn, rise;
  logic [DIV_W-1:0]         div_eff, div_inc;
  logic                     upd, skin_fail, air_fail, fail, cond;
  logic [CFG_W:0]           up_sum, floor_pad;
  logic [HOLD_W-1:0]        limit;

  always_comb begin
    skin      = sat_temp(item.skin_temp);
    air       = sat_temp(item.air_temp);
    btn       = {item.set_btn, item.down_btn, item.up_btn, item.stop_btn};
    rise      = btn & ~btn_prev_r;
    div_eff   = (cfg.update_divider == '0) ? DIV_W'(1) : cfg.update_divider;
    skin_fail = (skin <= ZERO_S) || (skin >= SENSOR_MAX_S);
    air_fail  = (air <= ZERO_S) || (air >= SENSOR_MAX_S);
    fail      = skin_fail || air_fail;

    sp_now_nxt       = sp_now_r;
    sp_draft_nxt     = sp_draft_r;
    edit_nxt         = edit_r;
    preheat_done_nxt = preheat_done_r;
    pending_nxt      = pending_r;
    sil_req_nxt      = sil_req_r;
    hold_act_nxt     = hold_act_r;
    hold_cnt_nxt     = hold_cnt_r;
    reached_nxt      = reached_r;
    heater_nxt       = heater_r;
    phase_nxt        = phase_r;
    class_nxt        = class_r;
    btn_prev_nxt     = btn;

    div_inc = div_cnt_r + DIV_W'(1);
    upd     = (div_inc >= div_eff);
    div_cnt_nxt = upd ? '0 : div_inc;

    up_sum    = '0;
    floor_pad = '0;
    sp_s      = '0;
    sp_lo     = '0;
    cond      = 1'b0;
    limit     = '0;

    if (!preheat_done_r) begin
      if (upd) begin
        if (skin >= to_s(cfg.preheat_target)) begin
          heater_nxt       = 1'b0;
          preheat_done_nxt = 1'b1;
        end else begin
          heater_nxt = !fail;
        end
      end
    end else begin
      // button edges
      if (rise[0]) sil_req_nxt = 1'b1;
      if (rise[1] && edit_r) begin
        up_sum = {1'b0, sp_draft_nxt} + (CFG_W+1)'(EDIT_STEP);
        sp_draft_nxt = (up_sum >= {1'b0, cfg.setpoint_ceiling}) ?
                       cfg.setpoint_ceiling : up_sum[CFG_W-1:0];
      end
      if (rise[2] && edit_r) begin
        floor_pad = {1'b0, cfg.setpoint_floor} + (CFG_W+1)'(EDIT_STEP);
        sp_draft_nxt = ({1'b0, sp_draft_nxt} <= floor_pad) ?
                       cfg.setpoint_floor : sp_draft_nxt - CFG_W'(EDIT_STEP);
      end
      if (rise[3]) begin
        edit_nxt = !edit_r;
        if (edit_r) sp_now_nxt = sp_draft_nxt;
      end
      sp_s  = to_s(sp_now_nxt);
      sp_lo = sp_s - LOW_MARGIN_S;

      // hold-off counter
      if (hold_act_r && (hold_cnt_r != HOLD_MAX)) hold_cnt_nxt = hold_cnt_r + HOLD_W'(1);

      // alarm
      cond = (skin > to_s(cfg.skin_alarm_high)) || (skin < sp_lo) ||
             (air > to_s(cfg.air_alarm_high));
      if (cond) begin
        priority if (skin > SKIN_CLASS_S)             class_nxt = ALARM_SKIN_HIGH;
        else if (skin < sp_lo)                        class_nxt = ALARM_SKIN_LOW;
        else if (air > to_s(cfg.air_alarm_high))      class_nxt = ALARM_AIR_HIGH;
        else                                          class_nxt = ALARM_NONE;
        if (!hold_act_r) pending_nxt = 1'b1;
        if (sil_req_nxt && !hold_act_r) begin
          hold_act_nxt = 1'b1;
          hold_cnt_nxt = '0;
          sil_req_nxt  = 1'b0;
          pending_nxt  = 1'b0;
        end
      end else begin
        class_nxt    = ALARM_NONE;
        pending_nxt  = 1'b0;
        hold_act_nxt = 1'b0;
        hold_cnt_nxt = '0;
      end

      // hold-off expiry
      limit = reached_r ? cfg.silence_short : cfg.silence_long;
      if (hold_cnt_nxt >= limit) begin
        hold_act_nxt = 1'b0;
        hold_cnt_nxt = '0;
      end
      if (!reached_r && (skin >= sp_s)) reached_nxt = 1'b1;

      // heater and buzzer
      if (fail) begin
        heater_nxt = 1'b0;
      end else if (upd) begin
        if (pending_nxt) phase_nxt = !phase_r;
        if (skin >= sp_s - OFF_MARGIN_S)     heater_nxt = 1'b0;
        else if (skin <= sp_s - ON_MARGIN_S) heater_nxt = 1'b1;
        if (air >= to_s(cfg.air_alarm_high)) heater_nxt = 1'b0;
      end
    end

    result.heater_on       = heater_nxt;
    result.buzzer_on       = pending_nxt && phase_nxt;
    result.alarm_kind      = class_nxt;
    result.skin_fail       = skin_fail;
    result.air_fail        = air_fail;
    result.editing         = edit_nxt;
    result.active_setpoint = sp_now_nxt;
    result.edit_setpoint   = sp_draft_nxt;
    result.preheating      = !preheat_done_nxt;
    result.update_tick     = upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_now_r       <= CFG_W'(SETPOINT_RESET);
      sp_draft_r     <= CFG_W'(SETPOINT_RESET);
      edit_r         <= 1'b0;
      preheat_done_r <= 1'b0;
      pending_r      <= 1'b0;
      sil_req_r      <= 1'b0;
      hold_act_r     <= 1'b0;
      hold_cnt_r     <= '0;
      reached_r      <= 1'b0;
      btn_prev_r     <= '0;
      heater_r       <= 1'b0;
      phase_r        <= 1'b0;
      div_cnt_r      <= '0;
      class_r        <= ALARM_NONE;
    end else if (step) begin
      sp_now_r       <= sp_now_nxt;
      sp_draft_r     <= sp_draft_nxt;
      edit_r         <= edit_nxt;
      preheat_done_r <= preheat_done_nxt;
      pending_r      <= pending_nxt;
      sil_req_r      <= sil_req_nxt;
      hold_act_r     <= hold_act_nxt;
      hold_cnt_r     <= hold_cnt_nxt;
      reached_r      <= reached_nxt;
      btn_prev_r     <= btn_prev_nxt;
      heater_r       <= heater_nxt;
      phase_r        <= phase_nxt;
      div_cnt_r      <= div_cnt_nxt;
      class_r        <= class_nxt;
    end
  end

endmodule

@@ hw/rtl/warmer_thermostat_alarm_core.sv @@
// Top level of the warmer thermostat/alarm block: stream ports, input and
// result registers, APB configuration. Depends on wta_pkg, wta_cfg_regs, wta_tick_logic.
`timescale 1ns / 1ps

// One input transaction is one 200 ms tick: skin and air readings (signed, 0.01 C,
// saturated in the block) plus four raw button levels. Each tick yields exactly one
// result transaction with heater and buzzer drive, alarm kind, sensor-fail
// flags, edit state, both setpoints, the preheat flag and the update-tick
// flag. Rate: one transaction per clock sustained while the output is not stalled;
// out_tvalid rises once the input register has captured the tick and the tick
// update has then loaded the result register; a stalled output can hold the tick
// in the input register in between. The tick update is one pass of combinational
// logic over the controller state, so ticks follow back to back; a stalled output
// fills the result register, then the input register, and then stalls the input.
// Configuration registers live at byte address 4*index on the APB port and
// must only be written while no transaction is in flight.

module warmer_thermostat_alarm_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // tdata fields, low bit up: skin_temp, air_temp, stop_btn, up_btn,
  // down_btn, set_btn
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [wta_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tdata fields, low bit up: heater_on, buzzer_on, alarm_kind, skin_fail,
  // air_fail, editing, active_setpoint, edit_setpoint, preheating,
  // update_tick, zero pad
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [wta_pkg::OUT_TDATA_W-1:0] out_tdata,
  // configuration
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [wta_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [wta_pkg::APB_DW-1:0]      cfg_pwdata,
  output logic [wta_pkg::APB_DW-1:0]      cfg_prdata,
  output logic                           cfg_pready
);
  import wta_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  item_t   s1_item_r;
  logic    s1_valid_r;
  logic    step_fire;
  result_t step_result;
  result_t out_result_r;
  logic    out_valid_r;

  assign cfg_pready = 1'b1;

  wta_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // unpack input transaction
  assign in_item.skin_temp = $signed(in_tdata[TEMP_BITS-1:0]);
  assign in_item.air_temp  = $signed(in_tdata[2*TEMP_BITS-1:TEMP_BITS]);
  assign in_item.stop_btn  = in_tdata[2*TEMP_BITS];
  assign in_item.up_btn    = in_tdata[2*TEMP_BITS+1];
  assign in_item.down_btn  = in_tdata[2*TEMP_BITS+2];
  assign in_item.set_btn   = in_tdata[2*TEMP_BITS+3];

  // tick advances from the input register whenever the result register is
  // free or being drained this cycle
  assign step_fire = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || step_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) s1_item_r <= in_item;
  end

  wta_tick_logic u_tick (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step_fire),
    .item   (s1_item_r),
    .cfg    (cfg),
    .result (step_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) out_result_r <= step_result;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}},
                       out_result_r.update_tick,
                       out_result_r.preheating,
                       out_result_r.edit_setpoint,
                       out_result_r.active_setpoint,
                       out_result_r.editing,
                       out_result_r.air_fail,
                       out_result_r.skin_fail,
                       out_result_r.alarm_kind,
                       out_result_r.buzzer_on,
                       out_result_r.heater_on};

  // preheat never raises an alarm
  a_preheat_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_result_r.preheating |->
      !out_result_r.buzzer_on && (out_result_r.alarm_kind == ALARM_NONE))
    else $error("alarm output during preheat");

  // a failed sensor forces the heater off once preheat is over
  a_fail_heater_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_result_r.preheating &&
      (out_result_r.skin_fail || out_result_r.air_fail) |-> !out_result_r.heater_on)
    else $error("heater on with failed sensor");

  // outside edit mode the draft equals the committed setpoint
  a_commit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_result_r.editing |->
      (out_result_r.active_setpoint == out_result_r.edit_setpoint))
    else $error("draft differs from committed setpoint outside edit mode");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for warmer_thermostat_alarm_core: drives tick transactions,
// predicts every status transaction in-bench and checks it. Depends on wta_pkg and the core.
`timescale 1ns / 1ps

module tb_top;
  import wta_pkg::*;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 11;
  localparam int DRAIN_CYCLES  = 4;     // covers the input and result registers
  localparam int STALL_LIMIT   = 4000;  // cycles without any accepted transaction
  localparam int SINK_HOLD_CYC = 400;   // long output back-pressure stretch
  localparam int MAX_REPORTS   = 10;
  localparam int HOLD_MAX      = (1 << HOLD_W) - 1;

  typedef enum int {
    SCN_NORMAL,
    SCN_SKIN_HOT,
    SCN_SKIN_COLD,
    SCN_AIR_HOT,
    SCN_SENSOR_FAULT,
    SCN_NOISE
  } scenario_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr   = '0;
  logic [APB_DW-1:0]      cfg_pwdata  = '0;
  logic [APB_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  warmer_thermostat_alarm_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // Controller shadow: register values and state; the state updates once per accepted tick
  // ---------------------------------------------------------------------------
  int          cfg_val [NUM_CFG];
  int          set_now, set_draft, hold_cnt, div_cnt;
  bit          editing_st, preheat_end, alarm_pend, silence_req, hold_on;
  bit          reached_once, heat_st, buzz_ph;
  alarm_kind_t alarm_cls;
  logic [3:0]  btn_last;   // {set, down, up, stop}

  result_t     pending_status [$];   // expected status, oldest first

  // bookkeeping
  int mismatch_count = 0;
  int ticks_sent     = 0;
  int results_seen   = 0;
  int cfg_writes     = 0;
  int settings_run   = 0;
  int preheat_ticks  = 0;
  int holdoff_starts = 0;
  int kinds_seen [4] = '{0, 0, 0, 0};
  int idle_cycles    = 0;

  // output-side pacing
  bit sink_hold_req = 1'b0;
  bit sink_steady   = 1'b0;
  int sink_stall    = 0;

  result_t got_status, want_status;
  string   diff_list;

  task automatic reset_model();
    cfg_val[REG_PREHEAT_TARGET]   = RST_PREHEAT_TARGET;
    cfg_val[REG_SKIN_ALARM_HIGH]  = RST_SKIN_ALARM_HIGH;
    cfg_val[REG_AIR_ALARM_HIGH]   = RST_AIR_ALARM_HIGH;
    cfg_val[REG_SETPOINT_CEILING] = RST_SETPOINT_CEILING;
    cfg_val[REG_SETPOINT_FLOOR]   = RST_SETPOINT_FLOOR;
    cfg_val[REG_SILENCE_SHORT]    = RST_SILENCE_SHORT;
    cfg_val[REG_SILENCE_LONG]     = RST_SILENCE_LONG;
    cfg_val[REG_UPDATE_DIVIDER]   = RST_UPDATE_DIVIDER;
    set_now      = SETPOINT_RESET;
    set_draft    = SETPOINT_RESET;
    hold_cnt     = 0;
    div_cnt      = 0;
    editing_st   = 1'b0;
    preheat_end  = 1'b0;
    alarm_pend   = 1'b0;
    silence_req  = 1'b0;
    hold_on      = 1'b0;
    reached_once = 1'b0;
    heat_st      = 1'b0;
    buzz_ph      = 1'b0;
    alarm_cls    = ALARM_NONE;
    btn_last     = 4'b0000;
  endtask

  function automatic int clamp_temp(input logic [TEMP_BITS-1:0] raw);
    int v;
    v = $signed(raw);
    if (v < TEMP_LOW) v = TEMP_LOW;
    if (v > TEMP_HIGH) v = TEMP_HIGH;
    return v;
  endfunction

  // One 200 ms tick of the thermostat/alarm controller.
  function automatic result_t step_controller(input logic [TEMP_BITS-1:0] skin_raw,
                                              input logic [TEMP_BITS-1:0] air_raw,
                                              input logic [3:0] btn);
    int         skin, air, sp, dv, d;
    logic [3:0] rise;
    bit         upd, skin_bad, air_bad, bad, cond;
    result_t    r;
    skin     = clamp_temp(skin_raw);
    air      = clamp_temp(air_raw);
    rise     = btn & ~btn_last;
    btn_last = btn;
    skin_bad = (skin <= 0) || (skin >= SENSOR_MAX);
    air_bad  = (air <= 0) || (air >= SENSOR_MAX);
    bad      = skin_bad || air_bad;
    // divider of zero behaves as one
    dv  = (cfg_val[REG_UPDATE_DIVIDER] == 0) ? 1 : cfg_val[REG_UPDATE_DIVIDER];
    upd = 1'b0;
    div_cnt++;
    if (div_cnt >= dv) begin
      upd     = 1'b1;
      div_cnt = 0;
    end

    if (!preheat_end) begin
      // buttons only recorded; no alarms during preheat
      if (upd) begin
        if (skin >= cfg_val[REG_PREHEAT_TARGET]) begin
          heat_st     = 1'b0;
          preheat_end = 1'b1;
        end else begin
          heat_st = !bad;
        end
      end
    end else begin
      if (rise[0]) silence_req = 1'b1;
      if (rise[1] && editing_st) begin
        d = set_draft + EDIT_STEP;
        set_draft = (d >= cfg_val[REG_SETPOINT_CEILING]) ? cfg_val[REG_SETPOINT_CEILING] : d;
      end
      if (rise[2] && editing_st) begin
        d = set_draft - EDIT_STEP;
        set_draft = (d <= cfg_val[REG_SETPOINT_FLOOR]) ? cfg_val[REG_SETPOINT_FLOOR] : d;
      end
      if (rise[3]) begin
        editing_st = !editing_st;
        if (!editing_st) set_now = set_draft;   // leaving edit mode commits
      end
      sp = set_now;

      if (hold_on && hold_cnt < HOLD_MAX) hold_cnt++;

      cond = (skin > cfg_val[REG_SKIN_ALARM_HIGH]) || (skin < sp - LOW_MARGIN) ||
             (air > cfg_val[REG_AIR_ALARM_HIGH]);
      if (cond) begin
        if (skin > SKIN_HIGH_CLASS)           alarm_cls = ALARM_SKIN_HIGH;
        else if (skin < sp - LOW_MARGIN)      alarm_cls = ALARM_SKIN_LOW;
        else if (air > cfg_val[REG_AIR_ALARM_HIGH]) alarm_cls = ALARM_AIR_HIGH;
        else                                  alarm_cls = ALARM_NONE;
        if (!hold_on) alarm_pend = 1'b1;
        if (silence_req && !hold_on) begin
          hold_on     = 1'b1;
          hold_cnt    = 0;
          silence_req = 1'b0;
          alarm_pend  = 1'b0;
          holdoff_starts++;
        end
      end else begin
        // condition gone: alarm and hold-off clear, silence latch stays
        alarm_cls  = ALARM_NONE;
        alarm_pend = 1'b0;
        hold_on    = 1'b0;
        hold_cnt   = 0;
      end

      if (reached_once) begin
        if (hold_cnt >= cfg_val[REG_SILENCE_SHORT]) begin
          hold_on  = 1'b0;
          hold_cnt = 0;
        end
      end else begin
        if (hold_cnt >= cfg_val[REG_SILENCE_LONG]) begin
          hold_on  = 1'b0;
          hold_cnt = 0;
        end
        if (skin >= sp) reached_once = 1'b1;
      end

      if (bad) begin
        heat_st = 1'b0;
      end else if (upd) begin
        if (alarm_pend) buzz_ph = !buzz_ph;
        if (skin >= sp - HEAT_OFF_MARGIN)      heat_st = 1'b0;
        else if (skin <= sp - HEAT_ON_MARGIN)  heat_st = 1'b1;
        if (air >= cfg_val[REG_AIR_ALARM_HIGH]) heat_st = 1'b0;
      end
    end

    r.heater_on       = heat_st;
    r.buzzer_on       = alarm_pend && buzz_ph;
    r.alarm_kind      = alarm_cls;
    r.skin_fail       = skin_bad;
    r.air_fail        = air_bad;
    r.editing         = editing_st;
    r.active_setpoint = CFG_W'(set_now);
    r.edit_setpoint   = CFG_W'(set_draft);
    r.preheating      = !preheat_end;
    r.update_tick     = upd;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Helpers: packing, formatting, error reporting
  // ---------------------------------------------------------------------------
  function automatic result_t unpack_status(input logic [OUT_TDATA_W-1:0] t);
    result_t r;
    r.heater_on       = t[0];
    r.buzzer_on       = t[1];
    r.alarm_kind      = alarm_kind_t'(t[3:2]);
    r.skin_fail       = t[4];
    r.air_fail        = t[5];
    r.editing         = t[6];
    r.active_setpoint = t[7 +: CFG_W];
    r.edit_setpoint   = t[7 + CFG_W +: CFG_W];
    r.preheating      = t[7 + 2 * CFG_W];
    r.update_tick     = t[8 + 2 * CFG_W];
    return r;
  endfunction

  function automatic string fmt_status(input result_t r);
    return $sformatf("htr=%b buz=%b kind=%0d sf=%b af=%b edit=%b sp=%0d draft=%0d pre=%b upd=%b",
                     r.heater_on, r.buzzer_on, r.alarm_kind, r.skin_fail, r.air_fail,
                     r.editing, r.active_setpoint, r.edit_setpoint, r.preheating,
                     r.update_tick);
  endfunction

  function automatic string field_diffs(input result_t e, input result_t a);
    string s;
    s = "";
    if (e.heater_on       !== a.heater_on)       s = {s, " heater_on"};
    if (e.buzzer_on       !== a.buzzer_on)       s = {s, " buzzer_on"};
    if (e.alarm_kind      !== a.alarm_kind)      s = {s, " alarm_kind"};
    if (e.skin_fail       !== a.skin_fail)       s = {s, " skin_fail"};
    if (e.air_fail        !== a.air_fail)        s = {s, " air_fail"};
    if (e.editing         !== a.editing)         s = {s, " editing"};
    if (e.active_setpoint !== a.active_setpoint) s = {s, " active_setpoint"};
    if (e.edit_setpoint   !== a.edit_setpoint)   s = {s, " edit_setpoint"};
    if (e.preheating      !== a.preheating)      s = {s, " preheating"};
    if (e.update_tick     !== a.update_tick)     s = {s, " update_tick"};
    return s;
  endfunction

  task automatic note_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  function automatic int reg_width(input cfg_idx_t idx);
    case (idx)
      REG_SILENCE_SHORT, REG_SILENCE_LONG: return HOLD_W;
      REG_UPDATE_DIVIDER:                  return DIV_W;
      default:                             return CFG_W;
    endcase
  endfunction

  // mostly zero, sometimes a short gap, rarely a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure plus one long requested hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (sink_hold_req) begin
      out_tready = 1'b0;
      repeat (SINK_HOLD_CYC) @(negedge clk);
      sink_hold_req = 1'b0;
    end else if (sink_stall > 0) begin
      out_tready = 1'b0;
      sink_stall--;
    end else if (!sink_steady && $urandom_range(0, 4) == 0) begin
      out_tready = 1'b0;
      sink_stall = gap_len();
    end else begin
      out_tready = 1'b1;
    end
  end

  // Each status transaction against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_status = unpack_status(out_tdata);
      results_seen++;
      if (pending_status.size() == 0) begin
        note_error($sformatf("unexpected status transaction %0d: %s", results_seen,
                             fmt_status(got_status)));
      end else begin
        want_status = pending_status.pop_front();
        diff_list   = field_diffs(want_status, got_status);
        if (out_tdata[OUT_TDATA_W-1:OUT_FIELD_W] !== '0) diff_list = {diff_list, " pad"};
        if (diff_list != "")
          note_error($sformatf("status %0d differs in%s\n  exp %s\n  act %s", results_seen,
                               diff_list, fmt_status(want_status), fmt_status(got_status)));
      end
    end
  end

  // Watchdog: any accepted transaction on any port resets the count
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles, %0d status pending",
               idle_cycles, pending_status.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus primitives
  // ---------------------------------------------------------------------------
  // Offer one tick transaction after an optional gap; prediction on acceptance.
  task automatic send_tick(input logic [TEMP_BITS-1:0] skin_raw,
                           input logic [TEMP_BITS-1:0] air_raw,
                           input logic [3:0] btn, input int gap);
    result_t exp_r;
    if (gap > 0) repeat (gap) @(negedge clk);
    in_tdata  = IN_TDATA_W'({btn, air_raw, skin_raw});
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    exp_r = step_controller(skin_raw, air_raw, btn);
    pending_status.push_back(exp_r);
    ticks_sent++;
    kinds_seen[exp_r.alarm_kind]++;
    if (exp_r.preheating) preheat_ticks++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic send_direct(input int skin, input int air, input logic [3:0] btn);
    send_tick(TEMP_BITS'(skin), TEMP_BITS'(air), btn, 0);
  endtask

  // Register write with readback; only issued with nothing in flight.
  task automatic write_reg(input cfg_idx_t idx, input int value);
    logic [APB_DW-1:0] wval;
    wval = APB_DW'(value) & ((APB_DW'(1) << reg_width(idx)) - 1);
    while (pending_status.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = CFG_AW'(int'(idx) * 4);
    cfg_pwdata  = wval;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_val[idx] = wval;
    cfg_writes++;
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== wval)
      note_error($sformatf("register %s reads %0d, wrote %0d", idx.name(), cfg_prdata, wval));
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic load_config(input int pre, input int skin_hi, input int air_hi,
                             input int ceil_v, input int floor_v, input int sil_short,
                             input int sil_long, input int divider);
    write_reg(REG_PREHEAT_TARGET,   pre);
    write_reg(REG_SKIN_ALARM_HIGH,  skin_hi);
    write_reg(REG_AIR_ALARM_HIGH,   air_hi);
    write_reg(REG_SETPOINT_CEILING, ceil_v);
    write_reg(REG_SETPOINT_FLOOR,   floor_v);
    write_reg(REG_SILENCE_SHORT,    sil_short);
    write_reg(REG_SILENCE_LONG,     sil_long);
    write_reg(REG_UPDATE_DIVIDER,   divider);
    settings_run++;
  endtask

  function automatic int fault_temp();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return SENSOR_MAX;
      2:       return SENSOR_MAX + $urandom_range(1, 80000);
      3:       return -$urandom_range(1, 20000);
      4:       return TEMP_LOW;
      5:       return TEMP_HIGH;
      6:       return 1;
      default: return SENSOR_MAX - 1;
    endcase
  endfunction

  // Runs of ticks that hold one thermal situation long enough for the
  // hysteresis, alarm and hold-off logic to play out; buttons wander.
  task automatic run_random_ticks(input int count, input bit steady);
    scenario_t  scn;
    int         left, skin, air, sp, pick;
    logic [3:0] btn;
    btn = 4'b0000;
    sink_steady = steady;
    while (count > 0) begin
      pick = $urandom_range(0, 99);
      scn  = (pick < 35) ? SCN_NORMAL :
             (pick < 50) ? SCN_SKIN_HOT :
             (pick < 65) ? SCN_SKIN_COLD :
             (pick < 80) ? SCN_AIR_HOT :
             (pick < 90) ? SCN_SENSOR_FAULT : SCN_NOISE;
      left = $urandom_range(4, 60);
      while (left > 0 && count > 0) begin
        sp   = set_now;
        skin = sp - 25 + $urandom_range(0, 60) - 30;   // straddles both heater thresholds
        air  = 3000 + $urandom_range(0, 900);
        case (scn)
          SCN_SKIN_HOT:
            if ($urandom_range(0, 1))
              skin = cfg_val[REG_SKIN_ALARM_HIGH] - 20 + $urandom_range(0, 150);
            else
              skin = SKIN_HIGH_CLASS - 3 + $urandom_range(0, 6);
          SCN_SKIN_COLD: skin = sp - LOW_MARGIN + 3 - $urandom_range(0, 300);
          SCN_AIR_HOT:   air  = cfg_val[REG_AIR_ALARM_HIGH] - 5 + $urandom_range(0, 100);
          SCN_SENSOR_FAULT:
            if ($urandom_range(0, 1)) skin = fault_temp();
            else                      air  = fault_temp();
          SCN_NOISE: begin
            skin = $urandom();
            air  = $urandom();
          end
          default: ;
        endcase
        for (int b = 0; b < 4; b++)
          if ($urandom_range(0, 4) == 0) btn[b] = ~btn[b];
        send_tick(TEMP_BITS'(skin), TEMP_BITS'(air), btn, steady ? 0 : gap_len());
        left--;
        count--;
      end
    end
    sink_steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Preheat with default divider of two: buttons ignored, sensor faults keep
  // the heater off, saturated extremes, preheat ends on an update tick.
  task automatic test_preheat();
    send_direct(2000, 3000, 4'b1111);
    send_direct(2000, 3000, 4'b0000);
    send_direct(0, 3000, 4'b0000);
    send_direct(2500, SENSOR_MAX, 4'b0000);
    send_direct(131071, -131072, 4'b1111);
    send_direct(-131072, 131071, 4'b0000);
    send_direct(2999, 3000, 4'b0000);
    send_direct(2999, 3000, 4'b0000);
    send_direct(3000, 3000, 4'b0000);
    send_direct(3000, 3000, 4'b0000);
  endtask

  // Edit mode: set toggles, up and down on rising edges, both together, commit.
  task automatic test_setpoint_edit();
    send_direct(3640, 3000, 4'b1000);
    send_direct(3640, 3000, 4'b0010);
    send_direct(3640, 3000, 4'b0000);
    send_direct(3640, 3000, 4'b0010);
    send_direct(3640, 3000, 4'b0110);
    send_direct(3640, 3000, 4'b0000);
    send_direct(3640, 3000, 4'b0110);
    send_direct(3640, 3000, 4'b1000);
  endtask

  // Each alarm kind, the condition-without-class case, silence, clearing,
  // and a failed sensor on each side.
  task automatic test_alarms();
    send_direct(3800, 3000, 4'b0000);
    send_direct(3730, 3000, 4'b0000);
    send_direct(3500, 3000, 4'b0000);
    send_direct(3650, 3950, 4'b0001);
    send_direct(3650, 3950, 4'b0000);
    send_direct(3650, 3000, 4'b0000);
    send_direct(SENSOR_MAX, 3000, 4'b0000);
    send_direct(3650, 0, 4'b0000);
  endtask

  task automatic test_default_config();
    load_config(RST_PREHEAT_TARGET, RST_SKIN_ALARM_HIGH, RST_AIR_ALARM_HIGH,
                RST_SETPOINT_CEILING, RST_SETPOINT_FLOOR, RST_SILENCE_SHORT,
                RST_SILENCE_LONG, RST_UPDATE_DIVIDER);
    run_random_ticks(150, 1'b1);
    run_random_ticks(250, 1'b0);
  endtask

  // Divider zero (every tick updates) and the shortest hold-offs.
  task automatic test_fast_divider();
    load_config(0, 3720, 3900, 3720, 3200, 0, 1, 0);
    run_random_ticks(300, 1'b0);
  endtask

  // Register maxima and minima, slowest divider.
  task automatic test_slow_divider();
    load_config((1 << CFG_W) - 1, (1 << CFG_W) - 1, 0, (1 << CFG_W) - 1, 0,
                HOLD_MAX, HOLD_MAX, (1 << DIV_W) - 1);
    run_random_ticks(150, 1'b0);
  endtask

  // Clamps at both ends, including ceiling below floor.
  task automatic test_inverted_clamps();
    load_config(3000, 3720, 3900, 0, (1 << CFG_W) - 1, 20, 30, 1);
    run_random_ticks(200, 1'b0);
    load_config(3000, 3720, 3900, (1 << CFG_W) - 1, 0, 20, 30, 3);
    run_random_ticks(100, 1'b0);
  endtask

  task automatic test_random_config();
    repeat (2) begin
      load_config($urandom_range(0, 5000), $urandom_range(3400, 3900),
                  $urandom_range(3500, 4200), $urandom_range(3500, 4000),
                  $urandom_range(3000, 3600), $urandom_range(1, 40),
                  $urandom_range(1, 40), $urandom_range(0, 15));
      run_random_ticks(150, 1'b0);
    end
    load_config($urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 8191),
                $urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 4095),
                $urandom_range(0, 4095), $urandom_range(0, 15));
    run_random_ticks(150, 1'b0);
  endtask

  // Result side holds off for a long stretch while ticks keep coming, so
  // the block fills and stalls its input.
  task automatic test_backpressure();
    @(posedge clk);
    sink_hold_req = 1'b1;
    @(negedge clk);
    run_random_ticks(40, 1'b1);
  endtask

  initial begin
    reset_model();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_preheat();
    test_setpoint_edit();
    test_alarms();
    test_default_config();
    test_fast_divider();
    test_slow_divider();
    test_inverted_clamps();
    test_random_config();
    test_backpressure();

    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d ticks (%0d in preheat), %0d status checked, %0d register writes",
             ticks_sent, preheat_ticks, results_seen, cfg_writes);
    $display("Summary: %0d settings; alarm kinds none/skin-high/skin-low/air-high %0d/%0d/%0d/%0d; %0d hold-offs",
             settings_run, kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3],
             holdoff_starts);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ warmer_thermostat_alarm_core.f @@
hw/rtl/wta_pkg.sv
hw/rtl/wta_cfg_regs.sv
hw/rtl/wta_tick_logic.sv
hw/rtl/warmer_thermostat_alarm_core.sv
verif/tb_top.sv
